FILE: hdl/cws_pkg.sv
package cws_pkg;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DIV,
    S_MOVE,
    S_MULY,
    S_ADD,
    S_OUT
  } state_t;

  localparam logic [1:0] CMD_START = 2'd0;
  localparam logic [1:0] CMD_DONE  = 2'd1;
  localparam logic [1:0] CMD_ABORT = 2'd2;

  localparam logic [2:0] CFG_TURN_COUNT  = 3'd0;
  localparam logic [2:0] CFG_COIL_WIDTH  = 3'd1;
  localparam logic [2:0] CFG_WIRE_PITCH  = 3'd2;
  localparam logic [2:0] CFG_FEED_RATE   = 3'd3;
  localparam logic [2:0] CFG_REVERSE_DIR = 3'd4;

  localparam int DIV_STEPS = 20;
  localparam int PL_W      = 21;
  localparam int AW        = 22;

endpackage

FILE: hdl/coil_winding_traverse_sequencer.sv
// Coil winding traverse sequencer.
// The in_ channel carries commands: tuser holds the command code and tdata
// the current Y and Z positions. A start transaction latches the positions
// and divides the coil width by the wire pitch, then issues the first move.
// Each completion transaction, or a start during a run, issues the next move;
// an abort stops the run and gives no result. The out_ channel gives one
// transaction per move with the Y and Z targets and the feed, or a finished
// transaction with tuser set once all turns are issued. The cfg_ channel
// writes the five registers and is always ready; the user must write it only
// while the block is idle, as the block itself does not enforce this. A start
// runs the shift-subtract divider, then the move sequence. A move is
// acceptance, then four steps through the one shared multiplier and the adders.
// Commands that give no result leave the block idle.
// The result sits in an output register; the next command is accepted while
// it waits, and a following result waits in the sequencer until the receiver
// takes the earlier one. Reset is synchronous and returns the registers to
// their defaults, the block to idle with no run active and no result pending.
module coil_winding_traverse_sequencer #(
  parameter int UNITS_PER_MM = 1000
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [63:0] in_tdata,  // origin_y[30:0], origin_z[61:31], zero pad
  input  logic [1:0]  in_tuser,  // cmd[1:0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [79:0] out_tdata, // target_y[31:0], target_z[63:32], move_feed[79:64]
  output logic        out_tuser, // finished[0]
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_addr,
  input  logic [19:0] cfg_data
);

  localparam int UW = $clog2(UNITS_PER_MM + 1);
  localparam int BW = ((UW > 16) ? UW : 16) + 1;
  localparam int PW = cws_pkg::AW + BW;
  localparam int SW = PW + 2;
  localparam int CW = $clog2(cws_pkg::DIV_STEPS);
  localparam logic [CW-1:0] DIV_LAST = CW'(cws_pkg::DIV_STEPS - 1);
  localparam logic signed [BW-1:0] UNITS_B = BW'(UNITS_PER_MM);
  localparam logic signed [SW-1:0] SAT_MAX = $signed({{(SW-31){1'b0}}, {31{1'b1}}});
  localparam logic signed [SW-1:0] SAT_MIN = $signed({{(SW-31){1'b1}}, 31'b0});
  localparam logic [cws_pkg::PL_W-1:0] PL_W_ONE = cws_pkg::PL_W'(1);

  cws_pkg::state_t state_r, state_nxt;

  logic [15:0] turn_count_r, turn_count_nxt;
  logic [19:0] coil_width_r, coil_width_nxt;
  logic [15:0] wire_pitch_r, wire_pitch_nxt;
  logic [15:0] feed_rate_r, feed_rate_nxt;
  logic        reverse_dir_r, reverse_dir_nxt;

  logic                          running_r, running_nxt;
  logic [15:0]                   turn_index_r, turn_index_nxt;
  logic signed [cws_pkg::PL_W-1:0] pass_length_r, pass_length_nxt;
  logic                          odd_layer_r, odd_layer_nxt;
  logic signed [cws_pkg::PL_W-1:0] pass_index_r, pass_index_nxt;
  logic signed [31:0]            base_y_r, base_y_nxt;
  logic signed [31:0]            base_z_r, base_z_nxt;

  logic [19:0]   dvd_r, dvd_nxt;
  logic [15:0]   rem_r, rem_nxt;
  logic [19:0]   quo_r, quo_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;

  logic signed [PW-1:0] prod_r, prod_nxt;
  logic signed [PW:0]   z_r, z_nxt;
  logic                 z_odd_r, z_odd_nxt;
  logic                 fin_r, fin_nxt;
  logic [31:0]          ty_r, ty_nxt;
  logic [31:0]          tz_r, tz_nxt;

  logic        out_valid_r, out_valid_nxt;
  logic [79:0] out_data_r, out_data_nxt;
  logic        out_fin_r, out_fin_nxt;

  logic in_acc;
  logic out_free;
  logic is_start;
  logic is_move;
  logic move_done;

  logic [16:0]                 trial;
  logic                        trial_ge;
  logic [19:0]                 quo_step;
  logic signed [cws_pkg::AW-1:0] diff;
  logic signed [cws_pkg::AW-1:0] mul_a;
  logic signed [BW-1:0]        mul_b;
  logic signed [PW-1:0]        mul_p;
  logic signed [cws_pkg::PL_W-1:0] limit;
  logic [16:0]                 ti_plus;
  logic signed [SW-1:0]        tz_sum;
  logic signed [SW-1:0]        ty_sum;
  logic signed [SW-1:0]        z_ext;
  logic signed [SW-1:0]        bz_ext;
  logic signed [SW-1:0]        by_ext;
  logic signed [SW-1:0]        py_ext;

  assign in_tready  = (state_r == cws_pkg::S_IDLE);
  assign cfg_ready  = 1'b1;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_fin_r;

  assign in_acc    = in_tvalid && in_tready;
  assign out_free  = !out_valid_r || out_tready;
  assign is_start  = (in_tuser == cws_pkg::CMD_START) && !running_r;
  assign is_move   = ((in_tuser == cws_pkg::CMD_START) || (in_tuser == cws_pkg::CMD_DONE))
                     && running_r;
  assign move_done = (turn_index_r >= turn_count_r);

  assign trial    = {rem_r, dvd_r[19]};
  assign trial_ge = (trial >= {1'b0, wire_pitch_r});
  assign quo_step = {quo_r[18:0], trial_ge};

  assign diff    = $signed({pass_length_r[cws_pkg::PL_W-1], pass_length_r})
                 - $signed({pass_index_r[cws_pkg::PL_W-1], pass_index_r});
  assign limit   = pass_length_r - $signed({{(cws_pkg::PL_W-1){1'b0}}, odd_layer_r});
  assign ti_plus = {1'b0, turn_index_r} + 17'd1;
  assign mul_p   = PW'(mul_a) * PW'(mul_b);

  assign z_ext  = $signed({{(SW-PW-1){z_r[PW]}}, z_r});
  assign bz_ext = $signed({{(SW-32){base_z_r[31]}}, base_z_r});
  assign by_ext = $signed({{(SW-32){base_y_r[31]}}, base_y_r});
  assign py_ext = $signed({{(SW-PW){prod_r[PW-1]}}, prod_r});
  assign tz_sum = reverse_dir_r ? (bz_ext - z_ext) : (bz_ext + z_ext);
  assign ty_sum = by_ext - py_ext;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      cws_pkg::S_IDLE: begin
        if (in_acc && is_start) begin
          state_nxt = cws_pkg::S_DIV;
        end else if (in_acc && is_move) begin
          state_nxt = cws_pkg::S_MOVE;
        end
      end
      cws_pkg::S_DIV: begin
        if (cnt_r == DIV_LAST) begin
          state_nxt = cws_pkg::S_MOVE;
        end
      end
      cws_pkg::S_MOVE: begin
        state_nxt = move_done ? cws_pkg::S_OUT : cws_pkg::S_MULY;
      end
      cws_pkg::S_MULY: state_nxt = cws_pkg::S_ADD;
      cws_pkg::S_ADD:  state_nxt = cws_pkg::S_OUT;
      cws_pkg::S_OUT: begin
        if (out_free) begin
          state_nxt = cws_pkg::S_IDLE;
        end
      end
      default: state_nxt = cws_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    turn_count_nxt  = turn_count_r;
    coil_width_nxt  = coil_width_r;
    wire_pitch_nxt  = wire_pitch_r;
    feed_rate_nxt   = feed_rate_r;
    reverse_dir_nxt = reverse_dir_r;
    running_nxt     = running_r;
    turn_index_nxt  = turn_index_r;
    pass_length_nxt = pass_length_r;
    odd_layer_nxt   = odd_layer_r;
    pass_index_nxt  = pass_index_r;
    base_y_nxt      = base_y_r;
    base_z_nxt      = base_z_r;
    dvd_nxt         = dvd_r;
    rem_nxt         = rem_r;
    quo_nxt         = quo_r;
    cnt_nxt         = cnt_r;
    prod_nxt        = prod_r;
    z_nxt           = z_r;
    z_odd_nxt       = z_odd_r;
    fin_nxt         = fin_r;
    ty_nxt          = ty_r;
    tz_nxt          = tz_r;
    out_valid_nxt   = out_valid_r;
    out_data_nxt    = out_data_r;
    out_fin_nxt     = out_fin_r;
    mul_a           = $signed({{(cws_pkg::AW-cws_pkg::PL_W){pass_index_r[cws_pkg::PL_W-1]}},
                               pass_index_r});
    mul_b           = $signed({{(BW-16){1'b0}}, wire_pitch_r});

    if (cfg_valid && cfg_ready) begin
      unique case (cfg_addr)
        cws_pkg::CFG_TURN_COUNT:  turn_count_nxt  = cfg_data[15:0];
        cws_pkg::CFG_COIL_WIDTH:  coil_width_nxt  = cfg_data;
        cws_pkg::CFG_WIRE_PITCH:  wire_pitch_nxt  = cfg_data[15:0];
        cws_pkg::CFG_FEED_RATE:   feed_rate_nxt   = cfg_data[15:0];
        cws_pkg::CFG_REVERSE_DIR: reverse_dir_nxt = cfg_data[0];
        default: ;
      endcase
    end

    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      cws_pkg::S_IDLE: begin
        if (in_acc) begin
          if (in_tuser == cws_pkg::CMD_ABORT) begin
            running_nxt = 1'b0;
          end else if (is_start) begin
            base_y_nxt     = $signed({in_tdata[30], in_tdata[30:0]});
            base_z_nxt     = $signed({in_tdata[61], in_tdata[61:31]});
            odd_layer_nxt  = 1'b0;
            pass_index_nxt = $signed(PL_W_ONE);
            turn_index_nxt = 16'd0;
            running_nxt    = 1'b1;
            dvd_nxt        = coil_width_r;
            rem_nxt        = 16'd0;
            quo_nxt        = 20'd0;
            cnt_nxt        = '0;
          end
        end
      end
      cws_pkg::S_DIV: begin
        dvd_nxt = {dvd_r[18:0], 1'b0};
        rem_nxt = trial_ge ? 16'(trial - {1'b0, wire_pitch_r}) : trial[15:0];
        quo_nxt = quo_step;
        cnt_nxt = cnt_r + CW'(1);
        if (cnt_r == DIV_LAST) begin
          pass_length_nxt = $signed({1'b0, quo_step}) - $signed(PL_W_ONE);
        end
      end
      cws_pkg::S_MOVE: begin
        if (move_done) begin
          running_nxt = 1'b0;
          fin_nxt     = 1'b1;
        end else begin
          fin_nxt   = 1'b0;
          z_odd_nxt = odd_layer_r;
          if (odd_layer_r) begin
            mul_a = diff;
          end
          prod_nxt = mul_p;
          if (pass_index_r >= limit) begin
            odd_layer_nxt  = !odd_layer_r;
            pass_index_nxt = '0;
          end else begin
            pass_index_nxt = pass_index_r + $signed(PL_W_ONE);
          end
        end
      end
      cws_pkg::S_MULY: begin
        z_nxt = $signed({prod_r[PW-1], prod_r})
              - $signed({{(PW+1-15){1'b0}}, (z_odd_r ? wire_pitch_r[15:1] : 15'd0)});
        mul_a    = $signed({{(cws_pkg::AW-17){1'b0}}, ti_plus});
        mul_b    = UNITS_B;
        prod_nxt = mul_p;
      end
      cws_pkg::S_ADD: begin
        if (ty_sum > SAT_MAX) begin
          ty_nxt = 32'h7fff_ffff;
        end else if (ty_sum < SAT_MIN) begin
          ty_nxt = 32'h8000_0000;
        end else begin
          ty_nxt = ty_sum[31:0];
        end
        if (tz_sum > SAT_MAX) begin
          tz_nxt = 32'h7fff_ffff;
        end else if (tz_sum < SAT_MIN) begin
          tz_nxt = 32'h8000_0000;
        end else begin
          tz_nxt = tz_sum[31:0];
        end
        turn_index_nxt = ti_plus[15:0];
      end
      cws_pkg::S_OUT: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_fin_nxt   = fin_r;
          out_data_nxt  = fin_r ? 80'd0 : {feed_rate_r, tz_r, ty_r};
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= cws_pkg::S_IDLE;
      turn_count_r  <= 16'd15;
      coil_width_r  <= 20'd4000;
      wire_pitch_r  <= 16'd1000;
      feed_rate_r   <= 16'd50;
      reverse_dir_r <= 1'b0;
      running_r     <= 1'b0;
      turn_index_r  <= 16'd0;
      pass_length_r <= '0;
      odd_layer_r   <= 1'b0;
      pass_index_r  <= '0;
      base_y_r      <= '0;
      base_z_r      <= '0;
      cnt_r         <= '0;
      out_valid_r   <= 1'b0;
    end else begin
      state_r       <= state_nxt;
      turn_count_r  <= turn_count_nxt;
      coil_width_r  <= coil_width_nxt;
      wire_pitch_r  <= wire_pitch_nxt;
      feed_rate_r   <= feed_rate_nxt;
      reverse_dir_r <= reverse_dir_nxt;
      running_r     <= running_nxt;
      turn_index_r  <= turn_index_nxt;
      pass_length_r <= pass_length_nxt;
      odd_layer_r   <= odd_layer_nxt;
      pass_index_r  <= pass_index_nxt;
      base_y_r      <= base_y_nxt;
      base_z_r      <= base_z_nxt;
      cnt_r         <= cnt_nxt;
      out_valid_r   <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    dvd_r      <= dvd_nxt;
    rem_r      <= rem_nxt;
    quo_r      <= quo_nxt;
    prod_r     <= prod_nxt;
    z_r        <= z_nxt;
    z_odd_r    <= z_odd_nxt;
    fin_r      <= fin_nxt;
    ty_r       <= ty_nxt;
    tz_r       <= tz_nxt;
    out_data_r <= out_data_nxt;
    out_fin_r  <= out_fin_nxt;
  end

`ifndef NO_ASSERTIONS
  a_fin_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> out_tdata == 80'd0)
    else $error("finished transaction carries nonzero data");

  a_start_div: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && (in_tuser == cws_pkg::CMD_START) && !running_r
    |=> state_r == cws_pkg::S_DIV)
    else $error("start transaction did not enter the divider");

  a_pass_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == cws_pkg::S_IDLE) && running_r && !pass_length_r[cws_pkg::PL_W-1]
    |-> pass_index_r <= pass_length_r)
    else $error("pass index beyond pass length");
`endif

endmodule
